// File: sv/cpack_pkg.sv
// ----------------------------------------------------------------------------
// cpack_pkg
// types and code constants shared by the cache-line word compressor
// ----------------------------------------------------------------------------
package cpack_pkg;

  localparam int WORD_W = 32;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 4;
  localparam int CODE_W = 34;
  localparam int RES_W  = 7;
  localparam int RCNT_W = 3;
  localparam int ACC_W  = CODE_W + RES_W;
  localparam int TOT_W  = 6;
  localparam int BCNT_W = 3;

  localparam logic [3:0] PFX_ZERO = 4'd0;
  localparam logic [3:0] PFX_ZEXT = 4'd11;
  localparam logic [3:0] PFX_FULL = 4'd1;
  localparam logic [3:0] PFX_TOP3 = 4'd7;
  localparam logic [3:0] PFX_TOP2 = 4'd3;
  localparam logic [3:0] PFX_LIT  = 4'd2;

  localparam logic [TOT_W-1:0] LEN_ZERO = 6'd2;
  localparam logic [TOT_W-1:0] LEN_ZEXT = 6'd12;
  localparam logic [TOT_W-1:0] LEN_FULL = 6'd6;
  localparam logic [TOT_W-1:0] LEN_TOP3 = 6'd16;
  localparam logic [TOT_W-1:0] LEN_TOP2 = 6'd24;
  localparam logic [TOT_W-1:0] LEN_LIT  = 6'd34;

  typedef enum logic [2:0] {
    CODE_ZERO,
    CODE_ZEXT,
    CODE_FULL,
    CODE_TOP3,
    CODE_TOP2,
    CODE_LIT
  } code_kind_t;

  typedef struct packed {
    code_kind_t       kind;
    logic [IDX_W-1:0] idx;
  } match_t;

  typedef struct packed {
    logic hi;
    logic mid;
    logic lo;
  } cell_hit_t;

endpackage

// File: sv/cpack_cell.sv
// ----------------------------------------------------------------------------
// cpack_cell
// one dictionary entry: shifts toward the older end on a push and compares
// its entry against the incoming word
// ----------------------------------------------------------------------------
module cpack_cell import cpack_pkg::*; (
  input  logic              clk,
  input  logic              shift_en,
  input  logic [WORD_W-1:0] entry_in,
  input  logic [WORD_W-1:0] data_word,
  output logic [WORD_W-1:0] entry_out,
  output cell_hit_t         hit
);

  logic [WORD_W-1:0] entry;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry <= entry_in;
    end
  end

  assign entry_out = entry;
  assign hit.hi    = (entry[31:16] == data_word[31:16]);
  assign hit.mid   = (entry[15:8] == data_word[15:8]);
  assign hit.lo    = (entry[7:0] == data_word[7:0]);

endmodule

// File: sv/cpack_dict.sv
// ----------------------------------------------------------------------------
// cpack_dict
// row of dictionary cells, newest entry in cell 0, with best-match select
// ----------------------------------------------------------------------------
module cpack_dict import cpack_pkg::*; #(
  parameter int DICT_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              block_start,
  input  logic [WORD_W-1:0] data_word,
  output match_t            match
);

  localparam int FW = $clog2(DICT_ENTRIES + 1);
  localparam int KW = $clog2(DICT_ENTRIES);

  logic [FW-1:0]           fill;
  logic [FW-1:0]           fill_eff;
  logic [FW-1:0]           fill_next;
  logic [WORD_W-1:0]       entries [DICT_ENTRIES];
  cell_hit_t               hits    [DICT_ENTRIES];
  logic [DICT_ENTRIES-1:0] m2;
  logic [DICT_ENTRIES-1:0] m3;
  logic [DICT_ENTRIES-1:0] m4;
  logic                    is_zero;
  logic                    is_zext;
  logic                    push;
  logic [KW-1:0]           sel;

  function automatic logic [KW-1:0] top_bit(input logic [DICT_ENTRIES-1:0] m);
    logic [KW-1:0] r;
    r = '0;
    for (int k = 0; k < DICT_ENTRIES; k++) begin
      if (m[k]) r = KW'(k);
    end
    return r;
  endfunction

  assign fill_eff = block_start ? '0 : fill;
  assign is_zero  = (data_word == '0);
  assign is_zext  = !is_zero && (data_word[31:8] == '0);
  assign push     = load && !is_zero && !is_zext;

  for (genvar k = 0; k < DICT_ENTRIES; k++) begin : g_cell
    logic [WORD_W-1:0] prev;
    if (k == 0) begin : g_head
      assign prev = data_word;
    end else begin : g_body
      assign prev = entries[k-1];
    end
    cpack_cell u_cell (
      .clk      (clk),
      .shift_en (push),
      .entry_in (prev),
      .data_word(data_word),
      .entry_out(entries[k]),
      .hit      (hits[k])
    );
    assign m2[k] = (FW'(k) < fill_eff) && hits[k].hi;
    assign m3[k] = m2[k] && hits[k].mid;
    assign m4[k] = m3[k] && hits[k].lo;
  end

  always_comb begin
    if (m4 != '0) begin
      sel = top_bit(m4);
    end else if (m3 != '0) begin
      sel = top_bit(m3);
    end else begin
      sel = top_bit(m2);
    end
    match.idx = IDX_W'(fill_eff) - IDX_W'(1) - IDX_W'(sel);
    if (is_zero) begin
      match.kind = CODE_ZERO;
    end else if (is_zext) begin
      match.kind = CODE_ZEXT;
    end else if (m4 != '0) begin
      match.kind = CODE_FULL;
    end else if (m3 != '0) begin
      match.kind = CODE_TOP3;
    end else if (m2 != '0) begin
      match.kind = CODE_TOP2;
    end else begin
      match.kind = CODE_LIT;
    end
  end

  always_comb begin
    fill_next = fill_eff;
    if (push && fill_eff != FW'(DICT_ENTRIES)) begin
      fill_next = fill_eff + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (load) begin
      fill <= fill_next;
    end
  end

endmodule

// File: sv/cpack_packer.sv
// ----------------------------------------------------------------------------
// cpack_packer
// builds the code for a word, merges it with residual bits and sends
// the completed bytes one beat at a time
// ----------------------------------------------------------------------------
module cpack_packer import cpack_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              last_word,
  input  match_t            match,
  input  logic [WORD_W-1:0] data_word,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              item_last,
  output logic              block_end
);

  logic [RES_W-1:0]  res;
  logic [RCNT_W-1:0] rcnt;
  logic [ACC_W-1:0]  acc;
  logic [BCNT_W-1:0] cnt;
  logic              last_q;
  logic [CODE_W-1:0] code;
  logic [TOT_W-1:0]  nbits;
  logic [ACC_W-1:0]  acc_next;
  logic [TOT_W-1:0]  total;
  logic [BCNT_W-1:0] nfull;
  logic [BCNT_W-1:0] cnt_next;
  logic [ACC_W-1:0]  rest;

  always_comb begin
    unique case (match.kind)
      CODE_ZERO: begin
        code  = CODE_W'(PFX_ZERO);
        nbits = LEN_ZERO;
      end
      CODE_ZEXT: begin
        code  = CODE_W'(PFX_ZEXT) | (CODE_W'(data_word[7:0]) << 4);
        nbits = LEN_ZEXT;
      end
      CODE_FULL: begin
        code  = CODE_W'(PFX_FULL) | (CODE_W'(match.idx) << 2);
        nbits = LEN_FULL;
      end
      CODE_TOP3: begin
        code  = CODE_W'(PFX_TOP3) | (CODE_W'(match.idx) << 4)
              | (CODE_W'(data_word[7:0]) << 8);
        nbits = LEN_TOP3;
      end
      CODE_TOP2: begin
        code  = CODE_W'(PFX_TOP2) | (CODE_W'(match.idx) << 4)
              | (CODE_W'(data_word[15:0]) << 8);
        nbits = LEN_TOP2;
      end
      CODE_LIT: begin
        code  = CODE_W'(PFX_LIT) | (CODE_W'(data_word) << 2);
        nbits = LEN_LIT;
      end
      default: begin
        code  = '0;
        nbits = LEN_ZERO;
      end
    endcase
  end

  assign acc_next = ACC_W'(res) | (ACC_W'(code) << rcnt);
  assign total    = TOT_W'(rcnt) + nbits;
  assign nfull    = total[TOT_W-1:3];
  assign cnt_next = nfull + BCNT_W'(last_word && total[2:0] != '0);
  assign rest     = acc_next >> {nfull, 3'b000};

  assign busy      = (cnt != '0);
  assign out_valid = busy;
  assign out_byte  = acc[BYTE_W-1:0];
  assign item_last = (cnt == BCNT_W'(1));
  assign block_end = item_last && last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      res  <= '0;
      rcnt <= '0;
    end else if (load) begin
      cnt  <= cnt_next;
      res  <= last_word ? '0 : rest[RES_W-1:0];
      rcnt <= last_word ? '0 : total[RCNT_W-1:0];
    end else if (out_valid && out_ready) begin
      cnt <= cnt - BCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc    <= acc_next;
      last_q <= last_word;
    end else if (out_valid && out_ready) begin
      acc <= acc >> BYTE_W;
    end
  end

endmodule

// File: sv/cpack_bitstream_compressor_top.sv
// ----------------------------------------------------------------------------
// cpack_bitstream_compressor_top
// compresses blocks of 32-bit words into a packed byte stream
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_ready   | data_word[31:0]
//  out     | output    | out_valid / out_ready | out_byte[7:0], item_last, block_end
//
// a word is taken when in_valid and in_ready are high; its bytes (0 to 6) then
// leave one per beat from the byte register, holding while out_ready is low
// in_ready stays low while bytes of the previous word are pending
// dictionary match, code build and merge all happen in the accept cycle
// reset clears the word position, dictionary fill and residual bits
module cpack_bitstream_compressor_top import cpack_pkg::*; #(
  parameter int DICT_ENTRIES    = 16,
  parameter int WORDS_PER_BLOCK = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] data_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              item_last,
  output logic              block_end
);

  localparam int PW = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;

  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic          load;
  logic          last_word;
  logic          busy;
  match_t        match;

  assign in_ready  = !busy;
  assign load      = in_valid && in_ready;
  assign last_word = (pos == PW'(WORDS_PER_BLOCK - 1));
  assign pos_next  = last_word ? '0 : pos + PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (load) begin
      pos <= pos_next;
    end
  end

  cpack_dict #(
    .DICT_ENTRIES(DICT_ENTRIES)
  ) u_dict (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .block_start(pos == '0),
    .data_word  (data_word),
    .match      (match)
  );

  cpack_packer u_packer (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .last_word(last_word),
    .match    (match),
    .data_word(data_word),
    .busy     (busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .item_last(item_last),
    .block_end(block_end)
  );

endmodule
